### sv/modexp_pkg.sv
`default_nettype none
package modexp_pkg;
  localparam int unsigned WIDTH_DEF = 64;
  localparam int unsigned FIELD_W = 64;

  // controller to datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RED_STEP,
    CMD_MUL_START,
    CMD_MUL_STEP,
    CMD_MUL_DONE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    sq_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic mul_done;
    logic expo_zero;
    logic expo_bit;
    logic mod_zero;
  } dp_status_t;
endpackage
`default_nettype wire

### sv/modexp_if.sv
`default_nettype none
interface modexp_in_if;
  logic                        valid;
  logic                        ready;
  logic [modexp_pkg::FIELD_W-1:0] base_value;
  logic [modexp_pkg::FIELD_W-1:0] exponent_value;
  modport source (output valid, base_value, exponent_value, input ready);
  modport sink (input valid, base_value, exponent_value, output ready);
endinterface

interface modexp_out_if;
  logic                        valid;
  logic                        ready;
  logic [modexp_pkg::FIELD_W-1:0] power_result;
  logic                        div_zero_error;
  modport source (output valid, power_result, div_zero_error, input ready);
  modport sink (input valid, power_result, div_zero_error, output ready);
endinterface
`default_nettype wire

### sv/modexp_dp.sv
`default_nettype none
module modexp_dp #(
  parameter int unsigned WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire modexp_pkg::dp_cmd_t            cmd,
  input  wire logic [modexp_pkg::FIELD_W-1:0] base_in,
  input  wire logic [modexp_pkg::FIELD_W-1:0] expo_in,
  input  wire logic [modexp_pkg::FIELD_W-1:0] mod_in,
  output modexp_pkg::dp_status_t              status,
  output logic [WIDTH-1:0]                    result
);
  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] m_r, expo_r, res_r, sq_r, addend_r, mult_r, acc_r;
  logic [WIDTH-1:0] red_r;
  logic [CW-1:0]    red_cnt_r;
  logic [WIDTH:0]   rem_sh, acc_sum, add_dbl;
  logic [WIDTH-1:0] acc_mod, add_mod, red_val;

  // restoring reduction of base: shift in one bit, subtract if fits
  always_comb begin
    rem_sh  = {red_r, expo_r[WIDTH-1]};
    red_val = (rem_sh >= {1'b0, m_r}) ? WIDTH'(rem_sh - {1'b0, m_r}) : rem_sh[WIDTH-1:0];
  end
  // modular add of accumulator and doubling of the addend
  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, addend_r};
    add_dbl = {addend_r, 1'b0};
    acc_mod = (acc_sum >= {1'b0, m_r}) ? WIDTH'(acc_sum - {1'b0, m_r}) : acc_sum[WIDTH-1:0];
    add_mod = (add_dbl >= {1'b0, m_r}) ? WIDTH'(add_dbl - {1'b0, m_r}) : add_dbl[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      modexp_pkg::CMD_LOAD: begin
        m_r       <= mod_in[WIDTH-1:0];
        expo_r    <= base_in[WIDTH-1:0];
        sq_r      <= expo_in[WIDTH-1:0];
        red_r     <= '0;
        red_cnt_r <= CW'(WIDTH);
        res_r     <= WIDTH'(1);
      end
      modexp_pkg::CMD_RED_STEP: begin
        // reduction uses expo_r as the shift source, sq_r holds exponent
        red_r     <= red_val;
        red_cnt_r <= red_cnt_r - CW'(1);
        if (red_cnt_r == CW'(1)) begin
          expo_r <= sq_r;
          sq_r   <= red_val;
        end else begin
          expo_r <= {expo_r[WIDTH-2:0], 1'b0};
        end
      end
      modexp_pkg::CMD_MUL_START: begin
        acc_r    <= '0;
        addend_r <= cmd.sq_sel ? sq_r : res_r;
        mult_r   <= sq_r;
      end
      modexp_pkg::CMD_MUL_STEP: begin
        if (mult_r[0]) acc_r <= acc_mod;
        addend_r <= add_mod;
        mult_r   <= mult_r >> 1;
      end
      modexp_pkg::CMD_MUL_DONE: begin
        if (cmd.sq_sel) begin
          sq_r   <= acc_r;
          expo_r <= expo_r >> 1;
        end else begin
          res_r <= acc_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.red_done  = (red_cnt_r == '0);
    status.mul_done  = (mult_r == '0);
    status.expo_zero = (expo_r == '0);
    status.expo_bit  = expo_r[0];
    status.mod_zero  = (m_r == '0);
    result           = res_r;
  end
endmodule
`default_nettype wire

### sv/modexp_ctrl.sv
`default_nettype none
module modexp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_fire,
  input  wire logic                   expo_in_zero,
  input  wire logic                   out_ready,
  input  wire modexp_pkg::dp_status_t status,
  output modexp_pkg::dp_cmd_t         cmd,
  output logic                        busy,
  output logic                        out_valid,
  output logic                        out_one,
  output logic                        out_err
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RED, S_BIT, S_MUL, S_MDONE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   sq_r, sq_nxt, one_r, one_nxt, err_r, err_nxt;
  logic   sel;

  always_comb begin
    state_nxt = state_r;
    sq_nxt    = sq_r;
    one_nxt   = one_r;
    err_nxt   = err_r;
    sel       = sq_r | !status.expo_bit;
    cmd.op    = modexp_pkg::CMD_NONE;
    cmd.sq_sel = sq_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op    = modexp_pkg::CMD_LOAD;
          one_nxt   = expo_in_zero;
          err_nxt   = 1'b0;
          sq_nxt    = 1'b0;
          state_nxt = expo_in_zero ? S_OUT : S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.mod_zero) begin
          err_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (status.red_done) state_nxt = S_BIT;
        else cmd.op = modexp_pkg::CMD_RED_STEP;
      end
      // multiply result by square on a set bit, then square
      S_BIT: begin
        if (status.expo_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op     = modexp_pkg::CMD_MUL_START;
          cmd.sq_sel = sel;
          sq_nxt     = sel;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        if (status.mul_done) state_nxt = S_MDONE;
        else cmd.op = modexp_pkg::CMD_MUL_STEP;
      end
      // after a square move to the next bit; after a multiply square next
      S_MDONE: begin
        cmd.op    = modexp_pkg::CMD_MUL_DONE;
        sq_nxt    = !sq_r;
        state_nxt = S_BIT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and command flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sq_r    <= 1'b0;
      one_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sq_r    <= sq_nxt;
      one_r   <= one_nxt;
      err_r   <= err_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_one   = one_r;
  assign out_err   = err_r;
endmodule
`default_nettype wire

### sv/modular_exponentiation_unit.sv
`default_nettype none
// Operation: the base is first reduced modulo the modulus, then per exponent
// bit an optional multiply and a square follow, each built from shift-and-add
// steps on two modular adders. One item at a time; a zero exponent answers in
// the cycle after accept, and a zero modulus answers by way of S_CHECK.
// Reset (rst_n, synchronous) clears the controller and the modulus to 0.
module modular_exponentiation_unit #(
  parameter int unsigned WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [modexp_pkg::FIELD_W-1:0] cfg_wdata,
  modexp_in_if.sink                           in_ch,
  modexp_out_if.source                        out_ch
);
  logic [modexp_pkg::FIELD_W-1:0] mod_r;
  modexp_pkg::dp_cmd_t            cmd;
  modexp_pkg::dp_status_t         status;
  logic [WIDTH-1:0]               result;
  logic busy, ovalid, one, err, in_fire;

  // hold modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= '0;
    else if (cfg_we) mod_r <= cfg_wdata;
  end

  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && !busy;

  modexp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .expo_in_zero(in_ch.exponent_value[WIDTH-1:0] == '0),
    .out_ready(out_ch.ready), .status(status), .cmd(cmd), .busy(busy),
    .out_valid(ovalid), .out_one(one), .out_err(err)
  );

  modexp_dp #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .base_in(in_ch.base_value),
    .expo_in(in_ch.exponent_value), .mod_in(mod_r),
    .status(status), .result(result)
  );

  assign out_ch.valid          = ovalid;
  assign out_ch.div_zero_error = err;
  assign out_ch.power_result   = one ? modexp_pkg::FIELD_W'(1) :
                                 err ? '0 : modexp_pkg::FIELD_W'(result);
endmodule
`default_nettype wire
